[src/cps_pkg.sv]
// Shared widths, select codes and helpers for the segment closest-point core.
`default_nettype none

package cps_pkg;

  localparam int CoordW  = 32;               // Q16.16 coordinate
  localparam int DiffW   = CoordW + 1;       // exact coordinate difference
  localparam int ProdW   = 2 * DiffW;        // product of two differences
  localparam int DotW    = ProdW + 1;        // sum of three products
  localparam int FracW   = 31;               // fraction bits of s and t
  localparam int QW      = FracW + 1;        // s and t, 0 to 1.0 inclusive
  localparam int WideW   = 2 * DotW;         // product of two dot products
  localparam int TnW     = DotW + QW + 1;    // b*s + f*2^31
  localparam int SnW     = DotW + 1;         // -c or b - c
  localparam int ScW     = DiffW + QW;       // delta magnitude times s
  localparam int SumW    = CoordW + 3;       // start plus rounded offset

  localparam int MulLat  = 3;
  localparam int DivLat  = FracW + 1;
  localparam int PipeLat = 3 + MulLat + 1 + DivLat + MulLat + 1 + DivLat + 3;

  localparam logic [CoordW-1:0] ThrReset = 32'd43;
  localparam logic [QW-1:0]     UnitQ    = {1'b1, {FracW{1'b0}}};

  localparam int CoordMax = 2147483647;
  localparam int CoordMin = -2147483647 - 1;

  typedef enum logic [1:0] {
    SSelZero,
    SSelFirst,
    SSelDiv
  } s_sel_e;

  typedef enum logic [1:0] {
    TSelZero,
    TSelOne,
    TSelDiv
  } t_sel_e;

  function automatic logic [CoordW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed(SumW'(CoordMax))) begin
      r = CoordW'(CoordMax);
    end else if (v < $signed(SumW'(CoordMin))) begin
      r = CoordW'(CoordMin);
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/cps_mul.sv]
// Three-stage signed multiplier built from four half-width partial products.
`default_nettype none

module cps_mul import cps_pkg::*; #(
  parameter int AW = DotW,
  parameter int BW = DotW
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW-1:0]    ua_q;
  logic [BW-1:0]    ub_q;
  logic             neg1_q, neg2_q;
  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    sum_w;
  logic [PW-1:0]    p_q;

  always_comb begin
    sum_w = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));
  end

  always_ff @(posedge clk_i) begin
    // magnitudes
    ua_q   <= a_i[AW-1] ? AW'(-a_i) : a_i;
    ub_q   <= b_i[BW-1] ? BW'(-b_i) : b_i;
    neg1_q <= a_i[AW-1] ^ b_i[BW-1];
    // partial products
    ll_q   <= ua_q[AL-1:0] * ub_q[BL-1:0];
    lh_q   <= ua_q[AL-1:0] * ub_q[BW-1:BL];
    hl_q   <= ua_q[AW-1:AL] * ub_q[BL-1:0];
    hh_q   <= ua_q[AW-1:AL] * ub_q[BW-1:BL];
    neg2_q <= neg1_q;
    // combine and restore sign
    p_q    <= neg2_q ? PW'(-sum_w) : sum_w;
  end

  assign p_o = $signed(p_q);

endmodule

`default_nettype wire

[src/cps_div.sv]
// Pipelined clamped divider: one quotient bit per stage, result in Q1.31.
`default_nettype none

module cps_div import cps_pkg::*; #(
  parameter int W  = WideW,
  parameter int SW = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic signed [W-1:0] num_i,
  input  wire logic signed [W-1:0] den_i,
  input  wire logic [SW-1:0]       side_i,
  output logic                     valid_o,
  output logic [QW-1:0]            quo_o,
  output logic [SW-1:0]            side_o
);

  localparam int Steps = FracW;

  logic [Steps:0]    vld_q;
  logic [Steps:0]    zero_q;
  logic [Steps:0]    one_q;
  logic [W-2:0]      rem_q  [Steps+1];
  logic [W-2:0]      den_q  [Steps+1];
  logic [FracW-1:0]  quo_q  [Steps+1];
  logic [SW-1:0]     side_q [Steps+1];

  logic [W-1:0]      trial [Steps];
  logic [W-1:0]      diff  [Steps];
  logic [W-2:0]      rem_d [Steps];
  logic [FracW-1:0]  quo_d [Steps];
  logic [Steps-1:0]  fit;
  logic              num_le0, num_ge_den;

  always_comb begin
    num_le0    = num_i[W-1] || (num_i == '0);
    num_ge_den = num_i >= den_i;
    for (int k = 0; k < Steps; k++) begin
      trial[k] = {rem_q[k], 1'b0};
      diff[k]  = trial[k] - {1'b0, den_q[k]};
      fit[k]   = trial[k] >= {1'b0, den_q[k]};
      rem_d[k] = fit[k] ? diff[k][W-2:0] : trial[k][W-2:0];
      quo_d[k] = {quo_q[k][FracW-2:0], fit[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i[W-2:0];
    den_q[0]  <= den_i[W-2:0];
    quo_q[0]  <= '0;
    zero_q[0] <= num_le0;
    one_q[0]  <= !num_le0 && num_ge_den;
    side_q[0] <= side_i;
    for (int k = 0; k < Steps; k++) begin
      rem_q[k+1]  <= rem_d[k];
      den_q[k+1]  <= den_q[k];
      quo_q[k+1]  <= quo_d[k];
      zero_q[k+1] <= zero_q[k];
      one_q[k+1]  <= one_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = one_q[Steps]  ? UnitQ :
                   zero_q[Steps] ? '0    : {1'b0, quo_q[Steps]};
  assign side_o  = side_q[Steps];

endmodule

`default_nettype wire

[src/closest_points_between_segments_core.sv]
// Top level of the closest-points-between-two-3D-segments core.
//
// Usage:
//   Input channel: drive the twelve Q16.16 coordinates and raise start_i. A
//   transfer happens at each rising edge with start_i high and busy_o low;
//   busy_o stays low, so one segment pair is taken every cycle.
//   Output channel: done_o is high for exactly one cycle with the two
//   closest points on the result ports. The receiver cannot stall, so every
//   result must be captured in that cycle.
//   Ordering: results appear in transfer order. Throughput is one pair per
//   cycle. The delay from transfer to result is set mostly by two 32-stage
//   divider pipelines (s of the unclamped solution, then the final s and t
//   in parallel) and two 3-stage wide multipliers.
//   Configuration: cfg_we_i writes cfg_wdata_i into the degenerate length
//   threshold (unsigned Q0.32 squared length); write it only while the pipe is empty.
//   Reset: rst_ni clears all valid bits and sets the threshold to 43; items
//   in flight are dropped.
`default_nettype none

module closest_points_between_segments_core import cps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CoordW-1:0] cfg_wdata_i,
  input  wire logic signed [CoordW-1:0] first_start_x_i,
  input  wire logic signed [CoordW-1:0] first_start_y_i,
  input  wire logic signed [CoordW-1:0] first_start_z_i,
  input  wire logic signed [CoordW-1:0] first_end_x_i,
  input  wire logic signed [CoordW-1:0] first_end_y_i,
  input  wire logic signed [CoordW-1:0] first_end_z_i,
  input  wire logic signed [CoordW-1:0] second_start_x_i,
  input  wire logic signed [CoordW-1:0] second_start_y_i,
  input  wire logic signed [CoordW-1:0] second_start_z_i,
  input  wire logic signed [CoordW-1:0] second_end_x_i,
  input  wire logic signed [CoordW-1:0] second_end_y_i,
  input  wire logic signed [CoordW-1:0] second_end_z_i,
  output logic                   done_o,
  output logic signed [CoordW-1:0] first_near_x_o,
  output logic signed [CoordW-1:0] first_near_y_o,
  output logic signed [CoordW-1:0] first_near_z_o,
  output logic signed [CoordW-1:0] second_near_x_o,
  output logic signed [CoordW-1:0] second_near_y_o,
  output logic signed [CoordW-1:0] second_near_z_o
);

  // Segment geometry carried down the whole pipe.
  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p2;
    logic [2:0][DiffW-1:0]  d1;
    logic [2:0][DiffW-1:0]  d2;
  } geo_t;

  // Dot products (a, e nonnegative) and degenerate flags.
  typedef struct packed {
    logic [DotW-1:0] a;
    logic [DotW-1:0] b;
    logic [DotW-1:0] c;
    logic [DotW-1:0] e;
    logic [DotW-1:0] f;
    logic            a_pt;
    logic            e_pt;
  } dots_t;

  typedef struct packed {
    geo_t  geo;
    dots_t dots;
  } mid_t;

  typedef struct packed {
    mid_t          mid;
    logic [QW-1:0] s0;
  } post_t;

  typedef struct packed {
    logic [QW-1:0] s0;
    s_sel_e        s_sel;
    t_sel_e        t_sel;
  } pick_t;

  logic              accept;
  logic [CoordW-1:0] thr_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: directions d1, d2 and offset r, all exact 33-bit values.
  // ---------------------------------------------------------------------
  logic [2:0][CoordW-1:0] s1_w, e1_w, s2_w, e2_w;
  geo_t                   a_geo_d, a_geo_q;
  logic [2:0][DiffW-1:0]  a_r_d, a_r_q;
  logic                   a_vld_q;

  assign s1_w = {first_start_z_i, first_start_y_i, first_start_x_i};
  assign e1_w = {first_end_z_i, first_end_y_i, first_end_x_i};
  assign s2_w = {second_start_z_i, second_start_y_i, second_start_x_i};
  assign e2_w = {second_end_z_i, second_end_y_i, second_end_x_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_geo_d.p1[k] = s1_w[k];
      a_geo_d.p2[k] = s2_w[k];
      a_geo_d.d1[k] = DiffW'($signed(e1_w[k])) - DiffW'($signed(s1_w[k]));
      a_geo_d.d2[k] = DiffW'($signed(e2_w[k])) - DiffW'($signed(s2_w[k]));
      a_r_d[k]      = DiffW'($signed(s1_w[k])) - DiffW'($signed(s2_w[k]));
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: the fifteen component products of the five dot products.
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0] pa_d [3], pe_d [3], pf_d [3], pc_d [3], pb_d [3];
  logic signed [ProdW-1:0] pa_q [3], pe_q [3], pf_q [3], pc_q [3], pb_q [3];
  geo_t                    b_geo_q;
  logic                    b_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = $signed(a_geo_q.d1[k]) * $signed(a_geo_q.d1[k]);
      pe_d[k] = $signed(a_geo_q.d2[k]) * $signed(a_geo_q.d2[k]);
      pf_d[k] = $signed(a_geo_q.d2[k]) * $signed(a_r_q[k]);
      pc_d[k] = $signed(a_geo_q.d1[k]) * $signed(a_r_q[k]);
      pb_d[k] = $signed(a_geo_q.d1[k]) * $signed(a_geo_q.d2[k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: sum the products, compare squared lengths with the threshold.
  // ---------------------------------------------------------------------
  dots_t c_dots_d;
  mid_t  c_mid_q;
  logic  c_vld_q;

  always_comb begin
    c_dots_d.a    = DotW'(pa_q[0]) + DotW'(pa_q[1]) + DotW'(pa_q[2]);
    c_dots_d.e    = DotW'(pe_q[0]) + DotW'(pe_q[1]) + DotW'(pe_q[2]);
    c_dots_d.f    = DotW'(pf_q[0]) + DotW'(pf_q[1]) + DotW'(pf_q[2]);
    c_dots_d.c    = DotW'(pc_q[0]) + DotW'(pc_q[1]) + DotW'(pc_q[2]);
    c_dots_d.b    = DotW'(pb_q[0]) + DotW'(pb_q[1]) + DotW'(pb_q[2]);
    c_dots_d.a_pt = c_dots_d.a <= DotW'(thr_q);
    c_dots_d.e_pt = c_dots_d.e <= DotW'(thr_q);
  end

  // ---------------------------------------------------------------------
  // Products of dot products for the unclamped s; hold geometry alongside.
  // ---------------------------------------------------------------------
  logic signed [WideW-1:0] ae_w, bb_w, bf_w, ce_w;
  mid_t                    mdl_q [MulLat];
  logic [MulLat-1:0]       mdl_vld_q;

  cps_mul #(.AW(DotW), .BW(DotW)) u_mul_ae (
    .clk_i, .a_i($signed(c_mid_q.dots.a)), .b_i($signed(c_mid_q.dots.e)), .p_o(ae_w)
  );
  cps_mul #(.AW(DotW), .BW(DotW)) u_mul_bb (
    .clk_i, .a_i($signed(c_mid_q.dots.b)), .b_i($signed(c_mid_q.dots.b)), .p_o(bb_w)
  );
  cps_mul #(.AW(DotW), .BW(DotW)) u_mul_bf (
    .clk_i, .a_i($signed(c_mid_q.dots.b)), .b_i($signed(c_mid_q.dots.f)), .p_o(bf_w)
  );
  cps_mul #(.AW(DotW), .BW(DotW)) u_mul_ce (
    .clk_i, .a_i($signed(c_mid_q.dots.c)), .b_i($signed(c_mid_q.dots.e)), .p_o(ce_w)
  );

  // ---------------------------------------------------------------------
  // Stage D: denominator a*e - b*b and numerator b*f - c*e. A denominator
  // that is not positive (parallel segments) forces s0 to zero.
  // ---------------------------------------------------------------------
  logic [WideW-1:0] denom_w, numer_w;
  logic             den_pos;
  logic [WideW-1:0] d_num_q, d_den_q;
  mid_t             d_mid_q;
  logic             d_vld_q;

  always_comb begin
    denom_w = ae_w - bb_w;
    numer_w = bf_w - ce_w;
    den_pos = !denom_w[WideW-1] && (denom_w != '0);
  end

  // Division for s0, the unclamped-t solution.
  logic          v1_w;
  logic [QW-1:0] s0_w;
  logic [$bits(mid_t)-1:0] side1_w;
  mid_t          m1_w;

  cps_div #(.W(WideW), .SW($bits(mid_t))) u_div_s0 (
    .clk_i, .rst_ni,
    .valid_i(d_vld_q),
    .num_i  ($signed(d_num_q)),
    .den_i  ($signed(d_den_q)),
    .side_i (d_mid_q),
    .valid_o(v1_w),
    .quo_o  (s0_w),
    .side_o (side1_w)
  );

  assign m1_w = mid_t'(side1_w);

  // tn numerator part b*s0; hold geometry and s0 alongside.
  logic signed [TnW-1:0] bs_w;
  post_t                 pdl_q [MulLat];
  logic [MulLat-1:0]     pdl_vld_q;
  post_t                 pm_w;

  cps_mul #(.AW(DotW), .BW(QW + 1)) u_mul_bs (
    .clk_i, .a_i($signed(m1_w.dots.b)), .b_i($signed({1'b0, s0_w})), .p_o(bs_w)
  );

  assign pm_w = pdl_q[MulLat-1];

  // ---------------------------------------------------------------------
  // Stage E: classify the case and set up the final s and t divisions.
  // ---------------------------------------------------------------------
  logic [TnW-1:0] tn_w, es_w;
  logic           tn_neg, tn_gt;
  pick_t          e_pick_d, e_pick_q;
  logic [SnW-1:0] e_sn_d, e_sn_q, e_sd_q;
  logic [TnW-1:0] e_tn_d, e_tn_q, e_td_q;
  geo_t           e_geo_q;
  logic           e_vld_q;

  always_comb begin
    tn_w   = bs_w + (TnW'($signed(pm_w.mid.dots.f)) << FracW);
    es_w   = TnW'(pm_w.mid.dots.e) << FracW;
    tn_neg = tn_w[TnW-1];
    tn_gt  = $signed(tn_w) > $signed(es_w);

    e_pick_d.s0    = pm_w.s0;
    e_pick_d.s_sel = SSelZero;
    e_pick_d.t_sel = TSelZero;
    e_sn_d         = SnW'(0) - SnW'($signed(pm_w.mid.dots.c));
    e_tn_d         = tn_w;

    case ({pm_w.mid.dots.a_pt, pm_w.mid.dots.e_pt})
      2'b11: begin
        e_pick_d.s_sel = SSelZero;
        e_pick_d.t_sel = TSelZero;
      end
      2'b10: begin
        // first segment is a point: t from f / e
        e_pick_d.s_sel = SSelZero;
        e_pick_d.t_sel = TSelDiv;
        e_tn_d         = TnW'($signed(pm_w.mid.dots.f)) << FracW;
      end
      2'b01: begin
        e_pick_d.s_sel = SSelDiv;
        e_pick_d.t_sel = TSelZero;
      end
      default: begin
        if (tn_neg) begin
          e_pick_d.s_sel = SSelDiv;
          e_pick_d.t_sel = TSelZero;
        end else if (tn_gt) begin
          // t clamps to one: recompute s from b - c
          e_pick_d.s_sel = SSelDiv;
          e_pick_d.t_sel = TSelOne;
          e_sn_d = SnW'($signed(pm_w.mid.dots.b)) - SnW'($signed(pm_w.mid.dots.c));
        end else begin
          e_pick_d.s_sel = SSelFirst;
          e_pick_d.t_sel = TSelDiv;
        end
      end
    endcase
  end

  // Final s and t dividers run side by side.
  logic                     v2_w, v3_w;
  logic [QW-1:0]            sq_w, tq_w;
  logic [$bits(pick_t)-1:0] side2_w;
  logic [$bits(geo_t)-1:0]  side3_w;
  pick_t                    pk_w;
  geo_t                     g3_w;

  cps_div #(.W(SnW), .SW($bits(pick_t))) u_div_s (
    .clk_i, .rst_ni,
    .valid_i(e_vld_q),
    .num_i  ($signed(e_sn_q)),
    .den_i  ($signed(e_sd_q)),
    .side_i (e_pick_q),
    .valid_o(v2_w),
    .quo_o  (sq_w),
    .side_o (side2_w)
  );

  cps_div #(.W(TnW), .SW($bits(geo_t))) u_div_t (
    .clk_i, .rst_ni,
    .valid_i(e_vld_q),
    .num_i  ($signed(e_tn_q)),
    .den_i  ($signed(e_td_q)),
    .side_i (e_geo_q),
    .valid_o(v3_w),
    .quo_o  (tq_w),
    .side_o (side3_w)
  );

  assign pk_w = pick_t'(side2_w);
  assign g3_w = geo_t'(side3_w);

  // ---------------------------------------------------------------------
  // Stage F: pick s and t, take delta magnitudes.
  // Stage G: scale magnitudes by s and t.
  // Stage H: round half away from zero, add to start, saturate.
  // ---------------------------------------------------------------------
  logic [QW-1:0]            s_fin, t_fin;
  logic [QW-1:0]            f_s_q, f_t_q;
  logic [2:0][DiffW-1:0]    f_m1_q, f_m2_q;
  logic [2:0]               f_n1_q, f_n2_q;
  logic [2:0][CoordW-1:0]   f_p1_q, f_p2_q;
  logic                     f_vld_q;
  logic [2:0][ScW-1:0]      g_x1_q, g_x2_q;
  logic [2:0]               g_n1_q, g_n2_q;
  logic [2:0][CoordW-1:0]   g_p1_q, g_p2_q;
  logic                     g_vld_q;
  logic [2:0][CoordW-1:0]   h_n1_d, h_n2_d, h_n1_q, h_n2_q;
  logic                     h_vld_q;
  logic [ScW-1:0]           rnd1 [3], rnd2 [3];
  logic [SumW-1:0]          off1 [3], off2 [3];

  always_comb begin
    case (pk_w.s_sel)
      SSelFirst: s_fin = pk_w.s0;
      SSelDiv:   s_fin = sq_w;
      default:   s_fin = '0;
    endcase
    case (pk_w.t_sel)
      TSelOne: t_fin = UnitQ;
      TSelDiv: t_fin = tq_w;
      default: t_fin = '0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd1[k]   = g_x1_q[k] + (ScW'(1) << (FracW - 1));
      rnd2[k]   = g_x2_q[k] + (ScW'(1) << (FracW - 1));
      off1[k]   = SumW'(rnd1[k][ScW-1:FracW]);
      off2[k]   = SumW'(rnd2[k][ScW-1:FracW]);
      h_n1_d[k] = sat32(SumW'($signed(g_p1_q[k])) +
                        $signed(g_n1_q[k] ? SumW'(-off1[k]) : off1[k]));
      h_n2_d[k] = sat32(SumW'($signed(g_p2_q[k])) +
                        $signed(g_n2_q[k] ? SumW'(-off2[k]) : off2[k]));
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      mdl_vld_q <= '0;
      d_vld_q   <= 1'b0;
      pdl_vld_q <= '0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
    end else begin
      a_vld_q   <= accept;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      mdl_vld_q <= {mdl_vld_q[MulLat-2:0], c_vld_q};
      d_vld_q   <= mdl_vld_q[MulLat-1];
      pdl_vld_q <= {pdl_vld_q[MulLat-2:0], v1_w};
      e_vld_q   <= pdl_vld_q[MulLat-1];
      f_vld_q   <= v2_w && v3_w;
      g_vld_q   <= f_vld_q;
      h_vld_q   <= g_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers; advance every cycle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    a_geo_q <= a_geo_d;
    a_r_q   <= a_r_d;

    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= pa_d[k];
      pe_q[k] <= pe_d[k];
      pf_q[k] <= pf_d[k];
      pc_q[k] <= pc_d[k];
      pb_q[k] <= pb_d[k];
    end
    b_geo_q <= a_geo_q;

    c_mid_q.geo  <= b_geo_q;
    c_mid_q.dots <= c_dots_d;

    mdl_q[0] <= c_mid_q;
    for (int k = 1; k < MulLat; k++) begin
      mdl_q[k] <= mdl_q[k-1];
    end

    d_num_q <= den_pos ? numer_w : '0;
    d_den_q <= den_pos ? denom_w : WideW'(1);
    d_mid_q <= mdl_q[MulLat-1];

    pdl_q[0].mid <= m1_w;
    pdl_q[0].s0  <= s0_w;
    for (int k = 1; k < MulLat; k++) begin
      pdl_q[k] <= pdl_q[k-1];
    end

    e_pick_q <= e_pick_d;
    e_sn_q   <= e_sn_d;
    e_sd_q   <= SnW'(pm_w.mid.dots.a);
    e_tn_q   <= e_tn_d;
    e_td_q   <= es_w;
    e_geo_q  <= pm_w.mid.geo;

    f_s_q <= s_fin;
    f_t_q <= t_fin;
    for (int k = 0; k < 3; k++) begin
      f_n1_q[k] <= g3_w.d1[k][DiffW-1];
      f_n2_q[k] <= g3_w.d2[k][DiffW-1];
      f_m1_q[k] <= g3_w.d1[k][DiffW-1] ? DiffW'(-g3_w.d1[k]) : g3_w.d1[k];
      f_m2_q[k] <= g3_w.d2[k][DiffW-1] ? DiffW'(-g3_w.d2[k]) : g3_w.d2[k];
    end
    f_p1_q <= g3_w.p1;
    f_p2_q <= g3_w.p2;

    for (int k = 0; k < 3; k++) begin
      g_x1_q[k] <= f_m1_q[k] * f_s_q;
      g_x2_q[k] <= f_m2_q[k] * f_t_q;
    end
    g_n1_q <= f_n1_q;
    g_n2_q <= f_n2_q;
    g_p1_q <= f_p1_q;
    g_p2_q <= f_p2_q;

    h_n1_q <= h_n1_d;
    h_n2_q <= h_n2_d;
  end

  assign done_o          = h_vld_q;
  assign first_near_x_o  = $signed(h_n1_q[0]);
  assign first_near_y_o  = $signed(h_n1_q[1]);
  assign first_near_z_o  = $signed(h_n1_q[2]);
  assign second_near_x_o = $signed(h_n2_q[0]);
  assign second_near_y_o = $signed(h_n2_q[1]);
  assign second_near_z_o = $signed(h_n2_q[2]);

endmodule

`default_nettype wire

[src/cps_chk.sv]
// Port-level checker for the segment closest-point core, with its bind.
`default_nettype none

module cps_chk import cps_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire logic [CoordW-1:0] first_start_x_i,
  input wire logic [CoordW-1:0] first_end_x_i,
  input wire logic [CoordW-1:0] first_near_x_o,
  input wire logic [CoordW-1:0] second_start_y_i,
  input wire logic [CoordW-1:0] second_end_y_i,
  input wire logic [CoordW-1:0] second_near_y_o
);

  // A result strobe always traces back to a transfer a fixed latency ago.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PipeLat))
    else $error("result without matching transfer");

  // Zero extent along an axis leaves that coordinate at the start point.
  a_first_flat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start_i && !busy_o && (first_start_x_i == first_end_x_i), PipeLat)
    |-> first_near_x_o == $past(first_start_x_i, PipeLat))
    else $error("first near x left a flat axis");

  a_second_flat_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start_i && !busy_o && (second_start_y_i == second_end_y_i), PipeLat)
    |-> second_near_y_o == $past(second_start_y_i, PipeLat))
    else $error("second near y left a flat axis");

endmodule

bind closest_points_between_segments_core cps_chk u_cps_chk (.*);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the segment closest-point core.
`default_nettype none

module tb_top;
  import cps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [199:0] wide_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct { coord_t c[12]; } seg_pair_t;
  typedef struct { coord_t c[6]; } near_pts_t;

  localparam int WatchLimit = 4000;
  localparam logic [QW-1:0] OneQ = UnitQ;

  logic clk_i, rst_ni, start_i, busy_o, cfg_we_i, done_o;
  logic [CoordW-1:0] cfg_wdata_i;
  coord_t drv_c[12];
  coord_t near_c[6];

  seg_pair_t pair_q[$];
  near_pts_t near_expected_q[$];
  seg_pair_t held_pair;
  logic [31:0] thr_model;
  int unsigned idle_pct;
  int unsigned mismatches;
  int unsigned stall_cycles;

  closest_points_between_segments_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .first_start_x_i(drv_c[0]), .first_start_y_i(drv_c[1]), .first_start_z_i(drv_c[2]),
    .first_end_x_i(drv_c[3]), .first_end_y_i(drv_c[4]), .first_end_z_i(drv_c[5]),
    .second_start_x_i(drv_c[6]), .second_start_y_i(drv_c[7]),
    .second_start_z_i(drv_c[8]), .second_end_x_i(drv_c[9]),
    .second_end_y_i(drv_c[10]), .second_end_z_i(drv_c[11]),
    .done_o,
    .first_near_x_o(near_c[0]), .first_near_y_o(near_c[1]), .first_near_z_o(near_c[2]),
    .second_near_x_o(near_c[3]), .second_near_y_o(near_c[4]),
    .second_near_z_o(near_c[5])
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Clamped quotient n/d in Q1.31, truncated; d is positive.
  function automatic logic [31:0] clamp_q31(wide_t n, wide_t d);
    if (n <= 0) return 32'd0;
    if (n >= d) return 32'(OneQ);
    return 32'((n <<< 31) / d);
  endfunction

  // delta * frac / 2^31, rounded to nearest, halves away from zero.
  function automatic wide_t scale_q31(wide_t d, logic [31:0] fr);
    logic [95:0] mag, q;
    mag = (d < 0) ? 96'(-d) : 96'(d);
    q = (mag * 96'(fr) + (96'd1 << 30)) >> 31;
    return (d < 0) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic coord_t clip32(wide_t v);
    if (v > wide_t'(CoordMax)) return coord_t'(CoordMax);
    if (v < wide_t'(CoordMin)) return coord_t'(CoordMin);
    return coord_t'(v);
  endfunction

  function automatic near_pts_t closest_points(seg_pair_t p, logic [31:0] thr);
    wide_t d1[3], d2[3], r[3];
    wide_t a, e, f, c, b, den, tn, es, thw;
    logic [31:0] s, t;
    bit a_pt, e_pt;
    near_pts_t res;
    a = 0; e = 0; f = 0; c = 0; b = 0; s = 0; t = 0;
    for (int k = 0; k < 3; k++) begin
      d1[k] = wide_t'(p.c[3+k]) - wide_t'(p.c[k]);
      d2[k] = wide_t'(p.c[9+k]) - wide_t'(p.c[6+k]);
      r[k]  = wide_t'(p.c[k]) - wide_t'(p.c[6+k]);
      a += d1[k] * d1[k];
      e += d2[k] * d2[k];
      f += d2[k] * r[k];
      c += d1[k] * r[k];
      b += d1[k] * d2[k];
    end
    thw = wide_t'(thr);
    a_pt = (a <= thw);
    e_pt = (e <= thw);
    if (a_pt && e_pt) begin
      s = 0; t = 0;
    end else if (a_pt) begin
      t = clamp_q31(f, e);
    end else if (e_pt) begin
      s = clamp_q31(-c, a);
    end else begin
      den = a * e - b * b;
      s = (den > 0) ? clamp_q31(b * f - c * e, den) : 32'd0;
      tn = b * wide_t'(s) + f * wide_t'(OneQ);
      es = e * wide_t'(OneQ);
      if (tn < 0) begin
        t = 0;
        s = clamp_q31(-c, a);
      end else if (tn > es) begin
        t = 32'(OneQ);
        s = clamp_q31(b - c, a);
      end else begin
        t = clamp_q31(tn, es);
      end
    end
    for (int k = 0; k < 3; k++) begin
      res.c[k]   = clip32(wide_t'(p.c[k]) + scale_q31(d1[k], s));
      res.c[3+k] = clip32(wide_t'(p.c[6+k]) + scale_q31(d2[k], t));
    end
    return res;
  endfunction

  // Driver: predict on each transfer, then advance to the next pending pair
  // or drop start for an idle cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      for (int k = 0; k < 12; k++) drv_c[k] <= '0;
    end else if (!start_i || !busy_o) begin
      if (start_i)
        near_expected_q.insert(near_expected_q.size(),
                               closest_points(held_pair, thr_model));
      if (pair_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        held_pair = pair_q.pop_front();
        for (int k = 0; k < 12; k++) drv_c[k] <= held_pair.c[k];
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (near_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        near_pts_t exp_pts;
        exp_pts = near_expected_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (near_c[k] !== exp_pts.c[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("coord %0d: expected %h actual %h", k, exp_pts.c[k], near_c[k]);
          end
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic coord_t rnd32();
    return coord_t'($urandom());
  endfunction

  // Pair near a random base, small spread for varied geometry, or full-range.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int unsigned kind, sc;
    coord_t base;
    kind = $urandom_range(9);
    sc = $urandom_range(20, 2);
    base = coord_t'($signed($urandom()) >>> $urandom_range(16, 2));
    for (int k = 0; k < 12; k++)
      p.c[k] = (kind < 2) ? rnd32() : base + coord_t'($signed($urandom()) >>> (31 - sc));
    case (kind)
      2: for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k] + coord_t'($urandom_range(3));
      3: for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k] - coord_t'($urandom_range(3));
      4, 5: begin
        // parallel: second direction is an integer multiple of the first
        int m;
        m = $urandom_range(4) - 2;
        for (int k = 0; k < 3; k++)
          p.c[9+k] = p.c[6+k] + coord_t'(m) * (p.c[3+k] - p.c[k]);
      end
      6: for (int k = 0; k < 12; k++) p.c[k] = $urandom_range(1) ? coord_t'(CoordMax)
                                                                : coord_t'(CoordMin);
      default: ;
    endcase
    return p;
  endfunction

  function automatic seg_pair_t mk(int v[12]);
    seg_pair_t p;
    for (int k = 0; k < 12; k++) p.c[k] = coord_t'(v[k] * 65536);
    return p;
  endfunction

  // Append one pair to the pending queue.
  task automatic queue_pair(seg_pair_t p);
    pair_q.insert(pair_q.size(), p);
  endtask

  task automatic drain_and_write(logic [31:0] thr);
    wait (pair_q.size() == 0 && !start_i && near_expected_q.size() == 0);
    repeat (PipeLat + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    thr_model = thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    seg_pair_t p;
    mismatches = 0;
    stall_cycles = 0;
    idle_pct = 38;
    thr_model = ThrReset;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: degenerate cases, parallel, crossing, clamps and extremes.
    queue_pair(mk('{1,2,3, 1,2,3, 4,5,6, 4,5,6}));
    queue_pair(mk('{1,1,1, 1,1,1, 0,0,0, 4,0,0}));
    queue_pair(mk('{0,0,0, 4,0,0, 2,3,0, 2,3,0}));
    queue_pair(mk('{0,0,0, 4,0,0, 0,1,0, 4,1,0}));
    queue_pair(mk('{0,0,0, 4,0,0, 5,1,0, 9,1,0}));
    queue_pair(mk('{-2,0,0, 2,0,0, 0,-2,1, 0,2,1}));
    queue_pair(mk('{0,0,0, 4,0,0, -3,1,0, -3,5,0}));
    queue_pair(mk('{0,0,0, 4,0,0, 2,3,0, 2,9,0}));
    queue_pair(mk('{0,0,0, 4,0,0, 2,-9,0, 2,-3,0}));
    queue_pair(mk('{0,0,0, 1,1,1, 7,-3,2, -5,4,-6}));
    for (int k = 0; k < 12; k++) p.c[k] = coord_t'(CoordMax);
    queue_pair(p);
    for (int k = 0; k < 12; k++) p.c[k] = coord_t'(CoordMin);
    queue_pair(p);
    for (int k = 0; k < 12; k++) p.c[k] = (k % 2) ? coord_t'(CoordMax) : coord_t'(CoordMin);
    queue_pair(p);
    for (int k = 0; k < 12; k++) p.c[k] = ((k / 3) % 2) ? coord_t'(CoordMax)
                                                         : coord_t'(CoordMin);
    queue_pair(p);
    for (int k = 0; k < 12; k++) p.c[k] = '0;
    queue_pair(p);
    for (int k = 0; k < 12; k++) p.c[k] = coord_t'(k[0]);
    queue_pair(p);
    repeat (300) queue_pair(random_pair());

    // Hold off until every result is back, then move the threshold.
    drain_and_write(32'd0);
    idle_pct = 87;
    repeat (300) queue_pair(random_pair());
    drain_and_write(32'hFFFF_FFFF);
    idle_pct = 0;
    repeat (100) queue_pair(random_pair());
    drain_and_write($urandom());
    repeat (300) queue_pair(random_pair());

    wait (pair_q.size() == 0 && !start_i && near_expected_q.size() == 0);
    repeat (PipeLat + 20) @(posedge clk_i);
    if (mismatches == 0 && near_expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
